>>> rtl/core/sbds_pkg.sv
package sbds_pkg;

	// Display geometry.
	localparam int NUM_DIGITS = 5;
	localparam int BAR_LEDS   = 21;
	localparam int QUO_W      = 21;   // bits of 20 * (bar_value - range_low)
	localparam int CNT_W      = 5;    // holds 0 .. BAR_LEDS
	localparam int MASK_W     = 26;

	// Command codes.
	localparam logic [1:0] OP_CHAR    = 2'd0;
	localparam logic [1:0] OP_BAR     = 2'd1;
	localparam logic [1:0] OP_REFRESH = 2'd2;

	// Register indexes.
	localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
	localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
	localparam logic [1:0] REG_BAR_MODE   = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [2:0]         digit_index;
		logic [7:0]         char_code;
		logic signed [15:0] bar_value;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  digit_select;
		logic [15:0] segment_word;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DRAW
	} state_t;

	// Seven-segment font for codes 0x20 .. 0x7F.
	localparam logic [7:0] FONT [0:95] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h40, 8'h80, 8'h00,
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h77, 8'h7F, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h7D,
		8'h76, 8'h06, 8'h0E, 8'h00, 8'h38, 8'h00, 8'h00, 8'h3F,
		8'h73, 8'h00, 8'h00, 8'h6D, 8'h00, 8'h3E, 8'h00, 8'h00,
		8'h00, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h5C, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
		8'h74, 8'h04, 8'h0C, 8'h00, 8'h30, 8'h00, 8'h54, 8'h5C,
		8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h00, 8'h00,
		8'h00, 8'h66, 8'h00, 8'h00, 8'h46, 8'h00, 8'h00, 8'h00
	};

	// Position of each bargraph LED in the 26-bit mask.
	localparam logic [MASK_W-1:0] LED_BIT [0:BAR_LEDS-1] = '{
		26'h2000000, 26'h1000000, 26'h0080000, 26'h0100000, 26'h0800000,
		26'h0400000, 26'h0040000, 26'h0200000, 26'h0020000, 26'h0010000,
		26'h0000001, 26'h0000002, 26'h0000004, 26'h0000008, 26'h0000010,
		26'h0000020, 26'h0000040, 26'h0000080, 26'h0000100, 26'h0000200,
		26'h0000400
	};

endpackage

>>> rtl/core/segment_bargraph_display_scanner.sv
// Multiplexed seven-segment display and bargraph scanner. A command item is
// taken when start is high and busy is low. A character write stores a font
// pattern in one digit word, and busy does not rise. A bargraph value
// scales (bar_value - range_low) against (range_high - range_low) into a
// count of 1 to 21 LEDs, drawn as a line or a dot into digit words 3 and
// 4. The scaling runs on one subtractor that produces one quotient bit per
// cycle, so busy stays high after the item is taken while the 21 quotient
// bits are formed and then while the mask is drawn; when the value is at
// or below the low end or the range is empty, only the draw step is made. A
// refresh tick presents the next digit word and its select on res for
// exactly one cycle, marked by res_valid, in the cycle after the item is
// taken. The receiver cannot stall: it must capture res whenever res_valid
// is high. Register writes are taken on any cycle cfg_we is high and should
// only be made while the block is idle.
module segment_bargraph_display_scanner import sbds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        res_valid,
	output res_t        res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers.
	logic signed [15:0] low_q;
	logic signed [15:0] high_q;
	logic               mode_q;

	// Display state.
	logic [15:0] digit_q [0:NUM_DIGITS-1];
	logic [2:0]  scan_q;

	// Sequencer and divider state.
	state_t             state_q, state_d;
	logic [QUO_W-1:0]   quo_q;    // dividend shifting out, quotient shifting in
	logic [15:0]        rem_q;
	logic [15:0]        dvs_q;
	logic [CNT_W-1:0]   step_q;
	logic               spec_q;
	logic [CNT_W-1:0]   spec_cnt_q;

	res_t res_q;
	logic res_valid_q;

	logic accept;
	logic div_en;
	logic draw_en;

	// Differences and special cases, evaluated when a bargraph item is taken.
	logic signed [16:0] diff_d;
	logic signed [16:0] span_r;
	logic               d_nonpos;
	logic               r_nonpos;
	logic [QUO_W-1:0]   dividend;

	assign accept   = start && !busy;
	assign diff_d   = {cmd.bar_value[15], cmd.bar_value} - {low_q[15], low_q};
	assign span_r   = {high_q[15], high_q} - {low_q[15], low_q};
	assign d_nonpos = diff_d[16] || (diff_d == 17'sd0);
	assign r_nonpos = span_r[16] || (span_r == 17'sd0);
	// 20 * d as 16 * d + 4 * d; d is positive here and fits in 16 bits.
	assign dividend = {1'b0, diff_d[15:0], 4'b0000} + {3'b000, diff_d[15:0], 2'b00};

	// One restoring division step.
	logic [16:0] rem_sh;
	logic        ge;
	logic [16:0] rem_sub;

	assign rem_sh  = {rem_q, quo_q[QUO_W-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	// LED count and mask.
	logic [CNT_W-1:0]  led_cnt;
	logic [MASK_W-1:0] mask;

	always_comb begin
		if (spec_q) begin
			led_cnt = spec_cnt_q;
		end else if (quo_q >= QUO_W'(BAR_LEDS - 1)) begin
			led_cnt = CNT_W'(BAR_LEDS);
		end else begin
			led_cnt = quo_q[CNT_W-1:0] + CNT_W'(1);
		end
	end

	always_comb begin
		mask = '0;
		if (mode_q) begin
			mask = LED_BIT[led_cnt - CNT_W'(1)];
		end else begin
			for (int i = 0; i < BAR_LEDS; i++) begin
				if (CNT_W'(i) < led_cnt) begin
					mask = mask | LED_BIT[i];
				end
			end
		end
	end

	// Font lookup for character writes.
	logic [6:0] ch;
	logic [6:0] font_idx;
	logic [7:0] glyph;
	logic       idx_ok;

	assign ch       = cmd.char_code[6:0];
	assign font_idx = ch - 7'h20;
	assign glyph    = ((ch >= 7'h20) ? FONT[font_idx] : 8'h00) | {cmd.char_code[7], 7'b0};
	assign idx_ok   = {1'b0, cmd.digit_index} < 4'(NUM_DIGITS);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd.opcode == OP_BAR) begin
					if (d_nonpos || r_nonpos) begin
						state_d = ST_DRAW;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (step_q == '0) begin
					state_d = ST_DRAW;
				end
			end
			ST_DRAW: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		busy    = 1'b1;
		div_en  = 1'b0;
		draw_en = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_DIV: begin
				div_en = 1'b1;
			end
			ST_DRAW: begin
				draw_en = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= 16'sd0;
			high_q <= 16'sd100;
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANGE_LOW:  low_q  <= cfg_data;
				REG_RANGE_HIGH: high_q <= cfg_data;
				REG_BAR_MODE:   mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Divider datapath. Payload only, so no reset.
	always_ff @(posedge clk) begin
		if (accept && cmd.opcode == OP_BAR) begin
			quo_q      <= dividend;
			rem_q      <= '0;
			dvs_q      <= span_r[15:0];
			step_q     <= CNT_W'(QUO_W - 1);
			spec_q     <= d_nonpos || r_nonpos;
			spec_cnt_q <= d_nonpos ? CNT_W'(1) : CNT_W'(BAR_LEDS);
		end else if (div_en) begin
			quo_q  <= {quo_q[QUO_W-2:0], ge};
			rem_q  <= ge ? rem_sub[15:0] : rem_sh[15:0];
			step_q <= step_q - CNT_W'(1);
		end
	end

	// Digit words and scan position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				digit_q[i] <= '0;
			end
			scan_q <= '0;
		end else begin
			if (accept && cmd.opcode == OP_CHAR && idx_ok) begin
				digit_q[cmd.digit_index] <= {8'h00, glyph};
			end
			if (draw_en) begin
				digit_q[4] <= {6'b0, mask[MASK_W-1:16]};
				digit_q[3] <= mask[15:0];
			end
			if (accept && cmd.opcode == OP_REFRESH) begin
				if ({1'b0, scan_q} == 4'(NUM_DIGITS - 1)) begin
					scan_q <= '0;
				end else begin
					scan_q <= scan_q + 3'd1;
				end
			end
		end
	end

	// Result register: one cycle per refresh, never held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= accept && cmd.opcode == OP_REFRESH;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.opcode == OP_REFRESH) begin
			res_q.digit_select <= scan_q;
			res_q.segment_word <= digit_q[scan_q];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// The scan position always names an existing digit.
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, scan_q} < 4'(NUM_DIGITS))
		else $error("scan position out of range");

	// A result only follows an accepted refresh, and the block is idle then.
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !busy)
		else $error("result while busy");

	// The last division step always hands over to the draw cycle.
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == '0) |=> state_q == ST_DRAW)
		else $error("division did not finish");

	// Drawing always returns to idle in the next cycle.
	a_draw_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAW |=> state_q == ST_IDLE)
		else $error("draw state held");

endmodule
